// ----- hdl/kssc_pkg.sv -----
// ----------------------------------------------------------------------------
// kssc_pkg
// Shared types and constants for the keyed substitution shift cipher:
// command and result word layouts, codes and table layout in the memory.
// ----------------------------------------------------------------------------
package kssc_pkg;

	// field widths
	localparam int CHAR_W       = 8;
	localparam int KEY_W        = 8;
	localparam int SPEC_CNT_W   = 6;
	localparam int ACTION_W     = 2;
	localparam int TSEL_W       = 2;
	localparam int ENTRY_W      = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	// class table sizes and their base addresses in the shared memory
	localparam int UPPER_DEPTH       = 26;
	localparam int LOWER_DEPTH       = 26;
	localparam int DIGIT_DEPTH       = 10;
	localparam int SPECIAL_DEPTH_DEF = 32;
	localparam int UPPER_BASE        = 0;
	localparam int LOWER_BASE        = UPPER_BASE + UPPER_DEPTH;
	localparam int DIGIT_BASE        = LOWER_BASE + LOWER_DEPTH;
	localparam int SPECIAL_BASE      = DIGIT_BASE + DIGIT_DEPTH;

	// character class bounds
	localparam logic [CHAR_W-1:0] CH_UPPER_LO = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_HI = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'h39;

	// command codes
	localparam logic [ACTION_W-1:0] ACT_ENCRYPT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DECRYPT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd2;

	// load targets
	localparam logic [TSEL_W-1:0] TSEL_UPPER   = 2'd0;
	localparam logic [TSEL_W-1:0] TSEL_LOWER   = 2'd1;
	localparam logic [TSEL_W-1:0] TSEL_DIGIT   = 2'd2;
	localparam logic [TSEL_W-1:0] TSEL_SPECIAL = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_KEY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_COUNT = 2'd1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   char_in;
		logic [TSEL_W-1:0]   table_select;
		logic [ENTRY_W-1:0]  entry_index;
	} cmd_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              mapped;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC,
		ST_FETCH
	} kssc_state_t;

endpackage

// ----- hdl/kssc_table_mem.sv -----
// ----------------------------------------------------------------------------
// kssc_table_mem
// Single memory holding all four class tables. One write and one read port,
// registered read data. Per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module kssc_table_mem
	import kssc_pkg::*;
#(
	parameter int DEPTH  = SPECIAL_BASE + SPECIAL_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CHAR_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [CHAR_W-1:0] rd_data_q;
	logic              rd_vld_q;

	// storage array and read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	// entry valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	// never-written entries read as zero
	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hdl/kssc_key_mod.sv -----
// ----------------------------------------------------------------------------
// kssc_key_mod
// Restoring remainder unit: key modulo class size, one key bit per cycle.
// Result valid once the last key bit is processed and held until the next start.
// ----------------------------------------------------------------------------
module kssc_key_mod
	import kssc_pkg::*;
#(
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	input  logic [CNT_W-1:0] divisor,
	output logic [CNT_W-1:0] rem,
	output logic             done
);

	localparam int STEP_W = $clog2(KEY_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(KEY_W - 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    shifted;
	logic [CNT_W-1:0]  rem_nxt;

	// one compare-subtract step
	always_comb begin
		shifted = {rem_q, key_q[KEY_W-1]};
		if (shifted >= {1'b0, div_q}) begin
			rem_nxt = CNT_W'(shifted - {1'b0, div_q});
		end else begin
			rem_nxt = CNT_W'(shifted);
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			key_q <= key_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

`ifndef SYNTH
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (div_q != '0) |-> rem_q < div_q)
		else $error("key remainder not below class size");

	a_run_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(run_q && done_q))
		else $error("remainder unit running and done at once");

	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !start |=> done_q)
		else $error("key remainder dropped before the next start");
`endif

endmodule

// ----- hdl/keyed_substitution_shift_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_substitution_shift_cipher_unit
// Keyed-alphabet shift cipher over four class tables held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on cmd is taken when start is high and busy low.
//   A load word writes one table entry in that cycle and leaves busy low.
//   An encrypt or decrypt word raises busy; the result word appears on
//   result for one cycle with done high. Unused action codes are dropped.
//   A result follows the table scan and the key reduction; a found
//   character adds one table fetch, one that passes through does not. The
//   class table size is 26, 26, 10 or the active special count. The table
//   scan reads one entry per cycle while the key remainder unit works bit by bit.
//   Busy drops with done, so a new word can be taken in the done cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high. Write only while busy is low.
//   Reset: tables read as zero, shift key and special count are zero.
//   The receiver cannot stall; results must be captured in the done cycle.
// ----------------------------------------------------------------------------
module keyed_substitution_shift_cipher_unit
	import kssc_pkg::*;
#(
	parameter int SPECIAL_DEPTH = SPECIAL_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_word_t             cmd,
	output logic                  done,
	output res_word_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MAX_DEPTH = (SPECIAL_DEPTH > UPPER_DEPTH) ? SPECIAL_DEPTH : UPPER_DEPTH;
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int MEM_DEPTH = SPECIAL_BASE + SPECIAL_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	kssc_state_t       state_q, state_d;

	logic [KEY_W-1:0]      shift_key_q;
	logic [SPEC_CNT_W-1:0] special_count_q;

	logic              accept;
	logic              crypt_go;
	logic              load_go;
	logic              load_ok;
	logic [ADDR_W-1:0] load_addr;

	logic [ADDR_W-1:0] cls_base;
	logic [CNT_W-1:0]  cls_n;
	logic [CNT_W-1:0]  spec_n;

	logic [CHAR_W-1:0] c_q;
	logic              decrypt_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cmp_ptr_s1;
	logic              cmp_vld_s1;
	logic              hit_q;
	logic [CNT_W-1:0]  pos_q;

	logic [CNT_W-1:0]  key_rem;
	logic              key_done;
	logic [CNT_W:0]    sum;
	logic [CNT_W-1:0]  new_pos;

	logic [ADDR_W-1:0] raddr;
	logic [CHAR_W-1:0] rdata;

	logic              scan_issue;
	logic              emit_pass;
	logic              emit_hit;
	logic              done_q;
	res_word_t         res_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign crypt_go  = accept && ((cmd.action == ACT_ENCRYPT) || (cmd.action == ACT_DECRYPT));
	assign load_go   = accept && (cmd.action == ACT_LOAD) && load_ok;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_key_q     <= '0;
			special_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SHIFT_KEY:     shift_key_q     <= cfg_data[KEY_W-1:0];
				CFG_SPECIAL_COUNT: special_count_q <= cfg_data[SPEC_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// active special entries, clipped to the table depth
	assign spec_n = (int'(special_count_q) > SPECIAL_DEPTH) ?
		CNT_W'(SPECIAL_DEPTH) : CNT_W'(special_count_q);

	// class of the incoming character
	always_comb begin
		if (cmd.char_in inside {[CH_UPPER_LO:CH_UPPER_HI]}) begin
			cls_base = ADDR_W'(UPPER_BASE);
			cls_n    = CNT_W'(UPPER_DEPTH);
		end else if (cmd.char_in inside {[CH_LOWER_LO:CH_LOWER_HI]}) begin
			cls_base = ADDR_W'(LOWER_BASE);
			cls_n    = CNT_W'(LOWER_DEPTH);
		end else if (cmd.char_in inside {[CH_DIGIT_LO:CH_DIGIT_HI]}) begin
			cls_base = ADDR_W'(DIGIT_BASE);
			cls_n    = CNT_W'(DIGIT_DEPTH);
		end else begin
			cls_base = ADDR_W'(SPECIAL_BASE);
			cls_n    = spec_n;
		end
	end

	// load target address and bounds check
	always_comb begin
		case (cmd.table_select)
			TSEL_UPPER: begin
				load_ok   = int'(cmd.entry_index) < UPPER_DEPTH;
				load_addr = ADDR_W'(UPPER_BASE) + ADDR_W'(cmd.entry_index);
			end
			TSEL_LOWER: begin
				load_ok   = int'(cmd.entry_index) < LOWER_DEPTH;
				load_addr = ADDR_W'(LOWER_BASE) + ADDR_W'(cmd.entry_index);
			end
			TSEL_DIGIT: begin
				load_ok   = int'(cmd.entry_index) < DIGIT_DEPTH;
				load_addr = ADDR_W'(DIGIT_BASE) + ADDR_W'(cmd.entry_index);
			end
			TSEL_SPECIAL: begin
				load_ok   = int'(cmd.entry_index) < SPECIAL_DEPTH;
				load_addr = ADDR_W'(SPECIAL_BASE) + ADDR_W'(cmd.entry_index);
			end
			default: begin
				load_ok   = 1'b0;
				load_addr = '0;
			end
		endcase
	end

	// shifted position, wrapped once around the class size
	always_comb begin
		if (decrypt_q) begin
			sum = {1'b0, pos_q} + {1'b0, n_q} - {1'b0, key_rem};
		end else begin
			sum = {1'b0, pos_q} + {1'b0, key_rem};
		end
		if (sum >= {1'b0, n_q}) begin
			sum = sum - {1'b0, n_q};
		end
		new_pos = sum[CNT_W-1:0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory read address
	always_comb begin
		state_d    = state_q;
		raddr      = base_q + ADDR_W'(rd_ptr_q);
		scan_issue = 1'b0;
		emit_pass  = 1'b0;
		emit_hit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (crypt_go) begin
					state_d = (cls_n == '0) ? ST_CALC : ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_issue = 1'b1;
				if (rd_ptr_q == n_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				raddr = base_q + ADDR_W'(new_pos);
				if (key_done) begin
					if (hit_q) begin
						state_d = ST_FETCH;
					end else begin
						emit_pass = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_FETCH: begin
				emit_hit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// compare stage valid, match flag and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			done_q     <= emit_pass || emit_hit;
			if (crypt_go) begin
				hit_q <= 1'b0;
			end else if (cmp_vld_s1 && (rdata == c_q)) begin
				hit_q <= 1'b1;
			end
		end
	end

	// item payload, scan pointer, match position and result word
	always_ff @(posedge clk) begin
		if (crypt_go) begin
			c_q       <= cmd.char_in;
			decrypt_q <= (cmd.action == ACT_DECRYPT);
			base_q    <= cls_base;
			n_q       <= cls_n;
			rd_ptr_q  <= '0;
		end else if (scan_issue) begin
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
		cmp_ptr_s1 <= rd_ptr_q;
		if (cmp_vld_s1 && (rdata == c_q)) begin
			pos_q <= cmp_ptr_s1;
		end
		if (emit_pass) begin
			res_q <= '{char_out: c_q, mapped: 1'b0};
		end else if (emit_hit) begin
			res_q <= '{char_out: rdata, mapped: 1'b1};
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// table memory
	kssc_table_mem #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (load_go),
		.waddr  (load_addr),
		.wdata  (cmd.char_in),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	// key reduction
	kssc_key_mod #(
		.CNT_W (CNT_W)
	) u_key_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (crypt_go),
		.key     (shift_key_q),
		.divisor (cls_n),
		.rem     (key_rem),
		.done    (key_done)
	);

`ifndef SYNTH
	a_done_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_CALC || state_q == ST_FETCH))
		else $error("result word without a finished item");

	a_mapped_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.mapped |-> $past(state_q == ST_FETCH))
		else $error("mapped result without a table fetch");

	a_crypt_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.action == ACT_ENCRYPT || cmd.action == ACT_DECRYPT)
		|=> busy)
		else $error("cipher word taken without going busy");
`endif

endmodule

// ----- tb/sv/keyed_substitution_shift_cipher_unit_tb.sv -----
// ----------------------------------------------------------------------------
// keyed_substitution_shift_cipher_unit_tb
// Self-checking bench for the keyed substitution shift cipher. A driver feeds
// command words from a queue, in random bursts and gaps. A shadow of the class
// tables and the two registers predicts each result word. A monitor checks
// every done strobe against the oldest prediction. Each phase reprograms the
// key and the special count, refills some tables with shuffled alphabets,
// and then runs encrypt and decrypt words mixed with noise loads and unused
// codes.
// ----------------------------------------------------------------------------
module keyed_substitution_shift_cipher_unit_tb;
	import kssc_pkg::*;

	localparam int SPEC_DEPTH   = SPECIAL_DEPTH_DEF;
	localparam int ITEMS        = 1200;
	localparam int OPS_PER_RUN  = 80;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 3000;

	// codes the package leaves unnamed
	localparam logic [ACTION_W-1:0]  ACT_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	cmd_word_t             cmd       = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	logic                  cfg_ready;
	res_word_t             result;

	// shadow of the block state
	logic [CHAR_W-1:0]     upper_tab [UPPER_DEPTH];
	logic [CHAR_W-1:0]     lower_tab [LOWER_DEPTH];
	logic [CHAR_W-1:0]     digit_tab [DIGIT_DEPTH];
	logic [CHAR_W-1:0]     spec_tab  [SPEC_DEPTH];
	logic [KEY_W-1:0]      key_reg  = '0;
	logic [SPEC_CNT_W-1:0] spec_cnt = '0;

	// special characters as queued for loading, used to aim the stimulus
	logic [CHAR_W-1:0]     spec_plan [SPEC_DEPTH];

	cmd_word_t pend_q [$];
	res_word_t cipher_q [$];

	int  gap_left    = 0;
	int  burst_left  = 1;
	bit  gaps_on     = 1'b1;
	int  n_gen       = 0;
	int  n_xform     = 0;
	int  n_hit       = 0;
	int  n_load      = 0;
	int  n_runs      = 0;
	int  n_fail      = 0;
	int  stall_count = 0;

	keyed_substitution_shift_cipher_unit #(
		.SPECIAL_DEPTH(SPEC_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		foreach (upper_tab[i]) upper_tab[i] = '0;
		foreach (lower_tab[i]) lower_tab[i] = '0;
		foreach (digit_tab[i]) digit_tab[i] = '0;
		foreach (spec_tab[i]) spec_tab[i] = '0;
		foreach (spec_plan[i]) spec_plan[i] = '0;
	end

	// apply one command word to the shadow; returns 1 when a result word follows
	function automatic bit cipher_step(input cmd_word_t w, output res_word_t r);
		logic [CHAR_W-1:0] tab [SPEC_DEPTH];
		logic [CHAR_W-1:0] c;
		int n, pos, k, np, idx;
		bit hit;
		c = w.char_in;
		idx = int'(w.entry_index);
		r = '0;
		pos = 0;
		hit = 1'b0;
		case (w.action)
			ACT_LOAD: begin
				case (w.table_select)
					TSEL_UPPER:   if (idx < UPPER_DEPTH) upper_tab[idx] = c;
					TSEL_LOWER:   if (idx < LOWER_DEPTH) lower_tab[idx] = c;
					TSEL_DIGIT:   if (idx < DIGIT_DEPTH) digit_tab[idx] = c;
					TSEL_SPECIAL: if (idx < SPEC_DEPTH) spec_tab[idx] = c;
					default: ;
				endcase
				return 1'b0;
			end
			ACT_ENCRYPT, ACT_DECRYPT: ;
			default: return 1'b0;
		endcase
		// pick the class table
		if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
			n = UPPER_DEPTH;
			for (int i = 0; i < UPPER_DEPTH; i++) tab[i] = upper_tab[i];
		end else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
			n = LOWER_DEPTH;
			for (int i = 0; i < LOWER_DEPTH; i++) tab[i] = lower_tab[i];
		end else if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
			n = DIGIT_DEPTH;
			for (int i = 0; i < DIGIT_DEPTH; i++) tab[i] = digit_tab[i];
		end else begin
			n = (int'(spec_cnt) > SPEC_DEPTH) ? SPEC_DEPTH : int'(spec_cnt);
			for (int i = 0; i < SPEC_DEPTH; i++) tab[i] = spec_tab[i];
		end
		// last match wins on duplicates
		for (int i = 0; i < n; i++)
			if (tab[i] == c) begin
				pos = i;
				hit = 1'b1;
			end
		if (!hit) begin
			r.char_out = c;
			r.mapped   = 1'b0;
			return 1'b1;
		end
		k  = int'(key_reg) % n;
		np = (w.action == ACT_ENCRYPT) ? (pos + k) % n : (pos + n - k) % n;
		r.char_out = tab[np];
		r.mapped   = 1'b1;
		return 1'b1;
	endfunction

	function automatic cmd_word_t mk(input logic [ACTION_W-1:0] a, input logic [CHAR_W-1:0] ch,
			input logic [TSEL_W-1:0] sel, input logic [ENTRY_W-1:0] idx);
		cmd_word_t w;
		w.action       = a;
		w.char_in      = ch;
		w.table_select = sel;
		w.entry_index  = idx;
		return w;
	endfunction

	task automatic push_word(input cmd_word_t w);
		pend_q.push_back(w);
		if (w.action != ACT_UNUSED) n_gen++;
	endtask

	// caller stands at a rising edge; returns at the edge that takes the write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SHIFT_KEY:     key_reg  = val;
			CFG_SPECIAL_COUNT: spec_cnt = val[SPEC_CNT_W-1:0];
			default: ;
		endcase
	endtask

	// wait for the block to go quiet, then let a possible scan finish
	task automatic wait_idle;
		do @(posedge clk); while (pend_q.size() != 0 || start || busy || cipher_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// queue a full table of shuffled class characters
	task automatic push_fill(input logic [TSEL_W-1:0] sel);
		logic [CHAR_W-1:0] vals [SPEC_DEPTH];
		logic [CHAR_W-1:0] t;
		int depth, j;
		case (sel)
			TSEL_UPPER:  depth = UPPER_DEPTH;
			TSEL_LOWER:  depth = LOWER_DEPTH;
			TSEL_DIGIT:  depth = DIGIT_DEPTH;
			default:     depth = SPEC_DEPTH;
		endcase
		for (int i = 0; i < depth; i++) begin
			case (sel)
				TSEL_UPPER: vals[i] = CH_UPPER_LO + CHAR_W'(i);
				TSEL_LOWER: vals[i] = CH_LOWER_LO + CHAR_W'(i);
				TSEL_DIGIT: vals[i] = CH_DIGIT_LO + CHAR_W'(i);
				default: begin
					do t = CHAR_W'($urandom_range(0, 255));
					while ((t >= CH_UPPER_LO && t <= CH_UPPER_HI) ||
						(t >= CH_LOWER_LO && t <= CH_LOWER_HI) ||
						(t >= CH_DIGIT_LO && t <= CH_DIGIT_HI));
					vals[i] = t;
				end
			endcase
		end
		for (int i = depth - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = vals[i];
			vals[i] = vals[j];
			vals[j] = t;
		end
		for (int i = 0; i < depth; i++) begin
			push_word(mk(ACT_LOAD, vals[i], sel, ENTRY_W'(i)));
			if (sel == TSEL_SPECIAL) spec_plan[i] = vals[i];
		end
	endtask

	// driver: present queued words in bursts, predict at acceptance
	always @(posedge clk) begin : driver_p
		res_word_t r;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				if (cmd.action == ACT_LOAD) n_load++;
				if (cipher_step(cmd, r)) begin
					cipher_q.push_back(r);
					n_xform++;
					if (r.mapped) n_hit++;
				end
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pend_q.size() != 0) begin
					cmd   <= pend_q.pop_front();
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 6);
						if (!gaps_on)
							gap_left = 0;
						else if ($urandom_range(0, 3) == 0)
							gap_left = $urandom_range(9, 40);
						else
							gap_left = $urandom_range(1, 8);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result word against the oldest prediction
	always @(posedge clk) begin : monitor_p
		res_word_t e;
		if (arst_n && done) begin
			if (cipher_q.size() == 0) begin
				$error("result word with none expected: char_out %02h mapped %0d",
					result.char_out, result.mapped);
				n_fail++;
			end else begin
				e = cipher_q.pop_front();
				if (result.char_out !== e.char_out) begin
					$error("char_out mismatch: expected %02h, got %02h", e.char_out, result.char_out);
					n_fail++;
				end
				if (result.mapped !== e.mapped) begin
					$error("mapped mismatch: expected %0d, got %0d", e.mapped, result.mapped);
					n_fail++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("stalled for %0d cycles with %0d results outstanding",
					stall_count, cipher_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin : stim_p
		int r, cnt_pick;
		logic [CHAR_W-1:0] ch;
		logic [KEY_W-1:0] key_pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset state: empty tables, no specials, unused code
		push_word(mk(ACT_ENCRYPT, "A", TSEL_UPPER, 5'd0));
		push_word(mk(ACT_DECRYPT, "z", TSEL_UPPER, 5'd0));
		push_word(mk(ACT_ENCRYPT, 8'h00, TSEL_UPPER, 5'd0));
		push_word(mk(ACT_UNUSED, 8'hFF, TSEL_SPECIAL, 5'h1F));
		wait_idle;

		// largest key, special count beyond the table depth
		cfg_write(CFG_SHIFT_KEY, 8'hFF);
		cfg_write(CFG_SPECIAL_COUNT, 8'd63);
		cfg_valid <= 1'b0;
		push_word(mk(ACT_ENCRYPT, 8'h00, TSEL_UPPER, 5'd0));
		push_word(mk(ACT_DECRYPT, 8'h00, TSEL_UPPER, 5'd0));
		push_word(mk(ACT_LOAD, "Q", TSEL_UPPER, 5'd0));
		push_word(mk(ACT_LOAD, "A", TSEL_UPPER, 5'd25));
		push_word(mk(ACT_LOAD, "Z", TSEL_UPPER, 5'd31));
		push_word(mk(ACT_LOAD, "m", TSEL_LOWER, 5'd7));
		push_word(mk(ACT_LOAD, "5", TSEL_DIGIT, 5'd9));
		push_word(mk(ACT_LOAD, "7", TSEL_DIGIT, 5'd12));
		push_word(mk(ACT_LOAD, 8'hFF, TSEL_SPECIAL, 5'd31));
		push_word(mk(ACT_LOAD, 8'h80, TSEL_SPECIAL, 5'd0));
		push_word(mk(ACT_ENCRYPT, "Q", TSEL_UPPER, 5'd0));
		push_word(mk(ACT_DECRYPT, "A", TSEL_UPPER, 5'd0));
		push_word(mk(ACT_ENCRYPT, "5", TSEL_DIGIT, 5'd0));
		push_word(mk(ACT_ENCRYPT, 8'hFF, TSEL_SPECIAL, 5'd0));
		push_word(mk(ACT_DECRYPT, 8'h80, TSEL_SPECIAL, 5'd0));
		push_word(mk(ACT_ENCRYPT, "B", TSEL_UPPER, 5'd0));
		push_word(mk(ACT_ENCRYPT, "m", TSEL_LOWER, 5'd0));
		push_word(mk(ACT_ENCRYPT, "7", TSEL_DIGIT, 5'd0));
		push_word(mk(ACT_DECRYPT, 8'h7F, TSEL_SPECIAL, 5'd0));

		// random runs: new settings, table refills, then cipher traffic
		for (int run = 0; n_gen < ITEMS; run++) begin
			wait_idle;
			case (run % 6)
				0: cnt_pick = 0;
				1: cnt_pick = 32;
				2: cnt_pick = 63;
				3: cnt_pick = 1;
				4: cnt_pick = 33;
				default: cnt_pick = $urandom_range(0, 63);
			endcase
			case (run % 4)
				0: key_pick = 8'd0;
				1: key_pick = 8'hFF;
				default: key_pick = KEY_W'($urandom_range(0, 255));
			endcase
			cfg_write(CFG_SHIFT_KEY, key_pick);
			cfg_write(CFG_SPECIAL_COUNT, {2'($urandom_range(0, 3)), 6'(cnt_pick)});
			if (run % 3 == 1) begin
				cfg_write(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 255)));
				cfg_write(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 255)));
			end
			cfg_valid <= 1'b0;
			gaps_on = (run % 3 != 2);
			n_runs++;

			for (int s = 0; s < 4; s++)
				if (run == 0 || $urandom_range(0, 1) == 1) push_fill(2'(s));

			repeat (OPS_PER_RUN) begin
				r = $urandom_range(0, 19);
				if (r == 0) begin
					ch = CHAR_W'($urandom_range(0, 255));
					push_word(mk(ACT_LOAD, ch, TSEL_W'($urandom_range(0, 3)),
						ENTRY_W'($urandom_range(0, 31))));
				end else if (r == 1) begin
					push_word(mk(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
						TSEL_W'($urandom_range(0, 3)), ENTRY_W'($urandom_range(0, 31))));
				end else begin
					case ($urandom_range(0, 9))
						0, 1:    ch = CH_UPPER_LO + CHAR_W'($urandom_range(0, UPPER_DEPTH - 1));
						2, 3:    ch = CH_LOWER_LO + CHAR_W'($urandom_range(0, LOWER_DEPTH - 1));
						4:       ch = CH_DIGIT_LO + CHAR_W'($urandom_range(0, DIGIT_DEPTH - 1));
						5, 6:    ch = spec_plan[$urandom_range(0, SPEC_DEPTH - 1)];
						default: ch = CHAR_W'($urandom_range(0, 255));
					endcase
					push_word(mk(($urandom_range(0, 1) == 1) ? ACT_DECRYPT : ACT_ENCRYPT, ch,
						TSEL_W'($urandom_range(0, 3)), ENTRY_W'($urandom_range(0, 31))));
				end
			end
		end
		wait_idle;

		$display("covered %0d cipher words (%0d found in a class table) and %0d table loads",
			n_xform, n_hit, n_load);
		$display("over %0d key and special count settings, with and without idle gaps", n_runs + 1);
		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
